@@ hdl/cass_pkg.sv @@
// types, table entry layout and sprite map for the corner autotile sprite selector
`timescale 1ns / 1ps

package cass_pkg;

	localparam int CORNERS = 4;
	localparam int ID_W    = 8;

	typedef logic        [ID_W-1:0]    tile_id_t;
	typedef logic signed [7:0]         prio_t;
	typedef logic        [CORNERS-1:0] corner_mask_t;
	typedef logic        [3:0]         sprite_t;

	typedef struct packed {
		logic  conn;
		prio_t prio;
	} kind_entry_t;

	// corner mask bits: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
	function automatic sprite_t sprite_of_mask(input corner_mask_t mask);
		sprite_t s;
		unique case (mask)
			4'b0001: s = 4'd7;
			4'b0010: s = 4'd8;
			4'b0011: s = 4'd2;
			4'b0100: s = 4'd5;
			4'b0101: s = 4'd1;
			4'b0110: s = 4'd13;
			4'b0111: s = 4'd10;
			4'b1000: s = 4'd6;
			4'b1001: s = 4'd14;
			4'b1010: s = 4'd4;
			4'b1011: s = 4'd9;
			4'b1100: s = 4'd3;
			4'b1101: s = 4'd12;
			4'b1110: s = 4'd11;
			4'b1111: s = 4'd0;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

@@ hdl/corner_autotile_sprite_select.sv @@
// corner autotile sprite selector: kind table, shared priority compare unit, sequencer
`timescale 1ns / 1ps

// channel | signals                              | moves
// --------+--------------------------------------+---------------------------------------
// input   | in_valid, in_ready, op, entry_*,     | one table load or one corner of tiles
//         | corner_*                             |
// output  | out_valid, out_ready, tile_id,       | one sprite word, last flags the final
//         | sprite_index, priority_res, last     | sprite of a corner
//
// a load word is taken while idle; a corner word goes through four table reads through the
// registered memory port, one pass of the shared compare unit per corner, then one sprite word
// per kept kind, or straight back to idle when no kind is kept
// reset clears the entry valid bits, so every kind reads priority 0, connect 0 until loaded
// in_ready is low from a corner accept until its last sprite is taken, or until no kind is
// kept; out_ready stalls hold the sprite word in place

module corner_autotile_sprite_select
	import cass_pkg::*;
#(
	parameter int TILE_KINDS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [7:0]          entry_id,
	input  logic signed [7:0]   entry_priority,
	input  logic                entry_connects,
	input  logic [7:0]          corner_top_left,
	input  logic [7:0]          corner_top_right,
	input  logic [7:0]          corner_bottom_left,
	input  logic [7:0]          corner_bottom_right,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          tile_id,
	output logic [3:0]          sprite_index,
	output logic signed [7:0]   priority_res,
	output logic                last
);

	localparam int DEPTH  = (TILE_KINDS < 256) ? TILE_KINDS : 256;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]         state_q;
	logic [2:0]         step_q;
	logic [1:0]         out_idx_q;

	kind_entry_t        mem_q [DEPTH];
	logic [DEPTH-1:0]   valid_q;

	tile_id_t           corner_q [CORNERS];
	prio_t              cprio_q  [CORNERS];
	logic               cconn_q  [CORNERS];
	corner_mask_t       mask_q   [CORNERS];
	corner_mask_t       lt_q     [CORNERS];
	corner_mask_t       kept_q;

	kind_entry_t        rd_data_s1;
	logic               rd_valid_s1;
	logic               rd_inrange_s1;

	logic               in_acc;
	logic               out_acc;
	logic               load_c;
	logic               wr_inrange_c;
	tile_id_t           rd_id_c;
	logic [ADDR_W-1:0]  rd_addr_c;
	logic               rd_inrange_c;
	kind_entry_t        rd_eff_c;
	prio_t              cand_c;
	corner_mask_t       eq_c;
	corner_mask_t       gt_c;
	logic               fresh_c;
	logic [2:0]         count_c;
	logic [2:0]         rank_c [CORNERS];
	logic [1:0]         sel_c;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign load_c   = in_acc && !op;

	assign wr_inrange_c = (32'(entry_id) < 32'(TILE_KINDS));

	// table read port, one corner per cycle
	assign rd_id_c      = corner_q[step_q[1:0]];
	assign rd_addr_c    = rd_id_c[ADDR_W-1:0];
	assign rd_inrange_c = (32'(rd_id_c) < 32'(TILE_KINDS));
	assign rd_eff_c     = (rd_valid_s1 && rd_inrange_s1) ? rd_data_s1 : '0;

	always_ff @(posedge clk) begin
		if (load_c && wr_inrange_c) begin
			mem_q[entry_id[ADDR_W-1:0]] <= '{conn: entry_connects, prio: entry_priority};
		end
		rd_data_s1    <= mem_q[rd_addr_c];
		rd_valid_s1   <= valid_q[rd_addr_c];
		rd_inrange_s1 <= rd_inrange_c;
	end

	// shared compare unit: one candidate priority against all four corners
	assign cand_c = cprio_q[step_q[1:0]];
	always_comb begin
		for (int j = 0; j < CORNERS; j++) begin
			eq_c[j] = (cprio_q[j] == cand_c);
			gt_c[j] = (cprio_q[j] > cand_c);
		end
	end
	// a kind whose priority matches an already kept kind is dropped
	assign fresh_c = (corner_q[step_q[1:0]] != '0) && !(|(eq_c & kept_q));

	// output ordering: kept priorities are distinct, so rank is the count of lower kept ones
	always_comb begin
		count_c = '0;
		sel_c   = '0;
		for (int i = 0; i < CORNERS; i++) begin
			count_c   = count_c + 3'(kept_q[i]);
			rank_c[i] = '0;
			for (int j = 0; j < CORNERS; j++) begin
				rank_c[i] = rank_c[i] + 3'(kept_q[j] & lt_q[i][j]);
			end
		end
		for (int i = 0; i < CORNERS; i++) begin
			if (kept_q[i] && (rank_c[i] == {1'b0, out_idx_q})) begin
				sel_c = 2'(i);
			end
		end
	end

	assign out_valid    = (state_q == S_OUT) && (count_c != '0);
	assign tile_id      = corner_q[sel_c];
	assign priority_res = cprio_q[sel_c];
	assign sprite_index = sprite_of_mask(mask_q[sel_c]);
	assign last         = (({1'b0, out_idx_q} + 3'd1) == count_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			out_idx_q <= '0;
			valid_q   <= '0;
			kept_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (load_c && wr_inrange_c) begin
						valid_q[entry_id[ADDR_W-1:0]] <= 1'b1;
					end
					if (in_acc && op) begin
						state_q   <= S_READ;
						step_q    <= '0;
						out_idx_q <= '0;
						kept_q    <= '0;
					end
				end
				S_READ: begin
					if (step_q == 3'd4) begin
						state_q <= S_CMP;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_CMP: begin
					kept_q[step_q[1:0]] <= fresh_c;
					if (step_q == 3'd3) begin
						state_q <= S_OUT;
					end
					step_q <= step_q + 3'd1;
				end
				S_OUT: begin
					if (count_c == '0) begin
						state_q <= S_IDLE;
					end else if (out_acc) begin
						out_idx_q <= out_idx_q + 2'd1;
						if (last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// corner words and per-corner results
	always_ff @(posedge clk) begin
		if (in_acc && op) begin
			corner_q[0] <= corner_top_left;
			corner_q[1] <= corner_top_right;
			corner_q[2] <= corner_bottom_left;
			corner_q[3] <= corner_bottom_right;
		end
		if ((state_q == S_READ) && (step_q != '0)) begin
			cprio_q[2'(step_q - 3'd1)] <= rd_eff_c.prio;
			cconn_q[2'(step_q - 3'd1)] <= rd_eff_c.conn;
		end
		if (state_q == S_CMP) begin
			mask_q[step_q[1:0]] <= eq_c | (gt_c & {CORNERS{cconn_q[step_q[1:0]]}});
			lt_q[step_q[1:0]]   <= ~(eq_c | gt_c);
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a sprite word is pending");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("block not ready after the last sprite");

	a_mesh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op |=> !in_ready && !out_valid)
		else $error("corner word did not start the table reads");

	a_sprite_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sprite_index <= 4'd14) && (sprite_index != 4'd0 || mask_q[sel_c] == 4'hf))
		else $error("sprite index from an empty mask");

endmodule

@@ test/corner_autotile_sprite_select_tb.sv @@
// testbench for the corner autotile sprite selector: table loads, corner words, sprite checks
`timescale 1ns / 1ps

module corner_autotile_sprite_select_tb;
	import cass_pkg::*;

	localparam int TILE_KINDS   = 256;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 30;
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_MESH    = 1'b1;

	// sprite variant per corner mask, mask 15 first
	localparam logic [15:0][3:0] SPRITE_LUT = {
		4'd0, 4'd11, 4'd12, 4'd3, 4'd9, 4'd4, 4'd14, 4'd6,
		4'd10, 4'd13, 4'd1, 4'd5, 4'd2, 4'd8, 4'd7, 4'd0
	};

	typedef struct packed {
		logic                   op;
		tile_id_t               entry_id;
		prio_t                  entry_priority;
		logic                   entry_connects;
		tile_id_t [CORNERS-1:0] corner;
	} tile_word_t;

	typedef struct packed {
		tile_id_t id;
		sprite_t  sprite;
		prio_t    prio;
		logic     last;
	} sprite_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [7:0]  entry_id;
	logic signed [7:0] entry_priority;
	logic        entry_connects;
	logic [7:0]  corner_top_left;
	logic [7:0]  corner_top_right;
	logic [7:0]  corner_bottom_left;
	logic [7:0]  corner_bottom_right;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  tile_id;
	logic [3:0]  sprite_index;
	logic signed [7:0] priority_res;
	logic        last;

	// own copy of the kind table
	prio_t        kind_prio_tbl [TILE_KINDS];
	logic         kind_conn_tbl [TILE_KINDS];
	sprite_word_t sprite_q [$];
	sprite_word_t want;

	bit idle_en;
	bit hold_req;
	int errors;
	int n_loads;
	int n_corners;
	int n_sprites;
	int idle_cycles;

	corner_autotile_sprite_select #(
		.TILE_KINDS(TILE_KINDS)
	) u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.op                  (op),
		.entry_id            (entry_id),
		.entry_priority      (entry_priority),
		.entry_connects      (entry_connects),
		.corner_top_left     (corner_top_left),
		.corner_top_right    (corner_top_right),
		.corner_bottom_left  (corner_bottom_left),
		.corner_bottom_right (corner_bottom_right),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.tile_id             (tile_id),
		.sprite_index        (sprite_index),
		.priority_res        (priority_res),
		.last                (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic prio_t rand_prio();
		// narrow range half the time so priorities collide
		if ($urandom_range(0, 1) == 0)
			return prio_t'(int'($urandom_range(0, 4)) - 2);
		return prio_t'($urandom_range(0, 255));
	endfunction

	function automatic tile_id_t rand_corner();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 8)
			return tile_id_t'($urandom_range(1, 12));
		return tile_id_t'($urandom_range(0, 255));
	endfunction

	// unused fields carry random bits
	function automatic tile_word_t mk_load(input tile_id_t id, input prio_t p, input logic c);
		tile_word_t w;
		w.op             = OP_LOAD;
		w.entry_id       = id;
		w.entry_priority = p;
		w.entry_connects = c;
		for (int i = 0; i < CORNERS; i++)
			w.corner[i] = tile_id_t'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic tile_word_t mk_mesh(input tile_id_t tl, input tile_id_t tr,
			input tile_id_t bl, input tile_id_t br);
		tile_word_t w;
		w.op             = OP_MESH;
		w.entry_id       = tile_id_t'($urandom_range(0, 255));
		w.entry_priority = prio_t'($urandom_range(0, 255));
		w.entry_connects = logic'($urandom_range(0, 1));
		w.corner[0]      = tl;
		w.corner[1]      = tr;
		w.corner[2]      = bl;
		w.corner[3]      = br;
		return w;
	endfunction

	function automatic tile_word_t rand_word();
		tile_id_t id;
		if ($urandom_range(0, 3) == 0) begin
			id = ($urandom_range(0, 4) == 0) ? tile_id_t'($urandom_range(0, 255))
				: tile_id_t'($urandom_range(0, 12));
			return mk_load(id, rand_prio(), logic'($urandom_range(0, 1)));
		end
		return mk_mesh(rand_corner(), rand_corner(), rand_corner(), rand_corner());
	endfunction

	function automatic prio_t table_prio(input tile_id_t id);
		if (int'(id) >= TILE_KINDS)
			return '0;
		return kind_prio_tbl[id];
	endfunction

	function automatic logic table_conn(input tile_id_t id);
		if (int'(id) >= TILE_KINDS)
			return 1'b0;
		return kind_conn_tbl[id];
	endfunction

	// update the table or queue the sprites that a corner word should give
	task automatic predict_sprites(input tile_word_t w);
		prio_t        cp [CORNERS];
		tile_id_t     kid [CORNERS];
		prio_t        kp [CORNERS];
		corner_mask_t km [CORNERS];
		tile_id_t     t_id;
		prio_t        t_prio;
		corner_mask_t t_mask;
		sprite_word_t s;
		int           n;
		int           j;
		bit           fresh;
		logic         up;
		if (w.op == OP_LOAD) begin
			n_loads++;
			if (int'(w.entry_id) < TILE_KINDS) begin
				kind_prio_tbl[w.entry_id] = w.entry_priority;
				kind_conn_tbl[w.entry_id] = w.entry_connects;
			end
			return;
		end
		n_corners++;
		n = 0;
		for (int i = 0; i < CORNERS; i++)
			cp[i] = table_prio(w.corner[i]);
		// first-seen kinds, a repeated priority is dropped
		for (int i = 0; i < CORNERS; i++) begin
			fresh = (w.corner[i] != '0);
			for (int k = 0; k < n; k++)
				if (kid[k] == w.corner[i] || kp[k] == cp[i])
					fresh = 0;
			if (fresh) begin
				kid[n] = w.corner[i];
				kp[n]  = cp[i];
				km[n]  = '0;
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			up = table_conn(kid[i]);
			for (int k = 0; k < CORNERS; k++)
				if (cp[k] == kp[i] || (cp[k] > kp[i] && up))
					km[i][k] = 1'b1;
		end
		for (int i = 1; i < n; i++) begin
			t_id   = kid[i];
			t_prio = kp[i];
			t_mask = km[i];
			j = i - 1;
			while (j >= 0 && kp[j] > t_prio) begin
				kid[j+1] = kid[j];
				kp[j+1]  = kp[j];
				km[j+1]  = km[j];
				j--;
			end
			kid[j+1] = t_id;
			kp[j+1]  = t_prio;
			km[j+1]  = t_mask;
		end
		for (int i = 0; i < n; i++) begin
			s.id     = kid[i];
			s.sprite = SPRITE_LUT[km[i]];
			s.prio   = kp[i];
			s.last   = (i == n - 1);
			sprite_q.insert(sprite_q.size(), s);
		end
	endtask

	task automatic send_word(input tile_word_t w);
		int gap;
		gap = idle_en ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid            <= 1'b1;
		op                  <= w.op;
		entry_id            <= w.entry_id;
		entry_priority      <= w.entry_priority;
		entry_connects      <= w.entry_connects;
		corner_top_left     <= w.corner[0];
		corner_top_right    <= w.corner[1];
		corner_bottom_left  <= w.corner[2];
		corner_bottom_right <= w.corner[3];
		do
			@(posedge clk);
		while (!in_ready);
		predict_sprites(w);
	endtask

	// sprite words checked in order against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (sprite_q.size() == 0) begin
				$error("sprite word with nothing expected: tile_id %0d", tile_id);
				errors++;
			end else begin
				want = sprite_q.pop_front();
				n_sprites++;
				if (tile_id !== want.id) begin
					$error("tile_id: expected %0d, got %0d", want.id, tile_id);
					errors++;
				end
				if (sprite_index !== want.sprite) begin
					$error("sprite_index: expected %0d, got %0d", want.sprite, sprite_index);
					errors++;
				end
				if (priority_res !== want.prio) begin
					$error("priority_res: expected %0d, got %0d", want.prio, priority_res);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold when asked
	initial begin
		int rx_gap;
		rx_gap    = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (!idle_en) begin
				out_ready <= 1'b1;
			end else if (rx_gap > 0) begin
				out_ready <= 1'b0;
				rx_gap--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					rx_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// nothing loaded yet: every kind reads priority 0, so at most one sprite per corner word
	task automatic test_unloaded_table();
		send_word(mk_mesh(8'd1, 8'd2, 8'd3, 8'd4));
		send_word(mk_mesh(8'd0, 8'd0, 8'd0, 8'd0));
		send_word(mk_mesh(8'd0, 8'd0, 8'd0, 8'd255));
	endtask

	task automatic test_directed_kinds();
		send_word(mk_load(8'd1, -8'sd128, 1'b0));
		send_word(mk_load(8'd2, 8'sd127, 1'b1));
		send_word(mk_load(8'd3, 8'sd0, 1'b1));
		send_word(mk_load(8'd255, 8'sd127, 1'b0));
		send_word(mk_load(8'd128, -8'sd1, 1'b1));
		// four distinct priorities
		send_word(mk_mesh(8'd2, 8'd1, 8'd128, 8'd3));
		// same priority under two ids, second dropped
		send_word(mk_mesh(8'd2, 8'd255, 8'd255, 8'd2));
		send_word(mk_mesh(8'd1, 8'd1, 8'd1, 8'd1));
		send_word(mk_mesh(8'd0, 8'd3, 8'd0, 8'd0));
		send_word(mk_mesh(8'd128, 8'd0, 8'd2, 8'd0));
		send_word(mk_mesh(8'd3, 8'd2, 8'd2, 8'd3));
		// empty corners through a loaded entry 0
		send_word(mk_load(8'd0, -8'sd128, 1'b1));
		send_word(mk_mesh(8'd0, 8'd3, 8'd0, 8'd2));
		send_word(mk_mesh(8'd1, 8'd0, 8'd0, 8'd0));
		send_word(mk_load(8'd0, 8'sd127, 1'b0));
		send_word(mk_mesh(8'd0, 8'd1, 8'd128, 8'd0));
		send_word(mk_load(8'd0, 8'sd0, 1'b0));
		send_word(mk_mesh(8'd255, 8'd128, 8'd1, 8'd3));
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++)
			send_word(rand_word());
	endtask

	// long receiver hold while corner words keep coming
	task automatic test_output_stall();
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_word(mk_mesh(rand_corner(), rand_corner(), rand_corner(), rand_corner()));
	endtask

	task automatic test_back_to_back(input int count);
		idle_en = 1'b0;
		for (int i = 0; i < count; i++)
			send_word(rand_word());
		idle_en = 1'b1;
	endtask

	initial begin
		errors              = 0;
		n_loads             = 0;
		n_corners           = 0;
		n_sprites           = 0;
		idle_cycles         = 0;
		idle_en             = 1'b1;
		hold_req            = 1'b0;
		arst_n              = 1'b0;
		in_valid            = 1'b0;
		op                  = OP_LOAD;
		entry_id            = '0;
		entry_priority      = '0;
		entry_connects      = 1'b0;
		corner_top_left     = '0;
		corner_top_right    = '0;
		corner_bottom_left  = '0;
		corner_bottom_right = '0;
		for (int i = 0; i < TILE_KINDS; i++) begin
			kind_prio_tbl[i] = '0;
			kind_conn_tbl[i] = 1'b0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_unloaded_table();
		test_directed_kinds();
		test_random_traffic(180);
		test_output_stall();
		test_back_to_back(40);
		test_random_traffic(180);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sprite_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d table loads and %0d corner words, %0d sprite words checked",
			n_loads, n_corners, n_sprites);
		$display("with random idling on both sides and one long output hold");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/cass_pkg.sv
hdl/corner_autotile_sprite_select.sv
test/corner_autotile_sprite_select_tb.sv
